/* design/physical_memory_region_decoder_assert.svh */
`ifndef PHYSICAL_MEMORY_REGION_DECODER_ASSERT_SVH
`define PHYSICAL_MEMORY_REGION_DECODER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define PMRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define PMRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pmrd_pkg.sv */
package pmrd_pkg;

    // region sizes in bytes
    localparam int unsigned MAIN_BYTES = 65536;
    localparam int unsigned ROM_BYTES  = 4096;
    localparam int unsigned SRAM_BYTES = 8192;

    // fixed region bases
    localparam logic [31:0] ROM_BASE    = 32'h2000_0000;
    localparam logic [31:0] SRAM_ORIGIN = 32'h0f00_0000;

    // byte banks, one per byte of the widest item
    localparam int unsigned LANES  = 8;
    localparam int unsigned LANE_W = 3;

    // rows of the shared banked store: main, then rom, then sram
    localparam int unsigned MAIN_ROWS  = MAIN_BYTES / LANES;
    localparam int unsigned ROM_ROWS   = ROM_BYTES / LANES;
    localparam int unsigned SRAM_ROWS  = SRAM_BYTES / LANES;
    localparam int unsigned TOTAL_ROWS = MAIN_ROWS + ROM_ROWS + SRAM_ROWS;
    localparam int unsigned ROW_W      = $clog2(TOTAL_ROWS);

    // clearing sweep covers rom and sram rows
    localparam int unsigned CLR_ROWS = ROM_ROWS + SRAM_ROWS;
    localparam int unsigned CLR_W    = $clog2(CLR_ROWS);

    // opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_DEVICE = 2'd1;
    localparam logic [1:0] ST_OOB    = 2'd2;

    // configuration register indexes
    localparam logic CFG_MAIN_BASE = 1'b0;
    localparam logic CFG_DEV_EN    = 1'b1;

    // stream widths
    localparam int unsigned IN_W  = 104;
    localparam int unsigned OUT_W = 72;

    // decoded access, held from acceptance until the result is loaded
    typedef struct packed {
        logic              access;
        logic              write;
        logic [ROW_W-1:0]  row;
        logic [LANE_W-1:0] lane;
        logic [3:0]        len;
        logic [63:0]       wdata;
        logic [1:0]        status;
    } t_req;

endpackage

/* design/physical_memory_region_decoder.sv */
// channel   | dir | payload, lowest bit first
// s_axis    | in  | opcode[1:0] address[33:2] access_bytes[37:34] write_data[101:38]
// m_axis    | out | read_data[63:0] status[65:64]
// i_cfg     | in  | index 0 main_base, index 1 device_enable
//
// an item takes three steps: acceptance with decode, bank access, result load
// the next item is taken once the previous result sits in the output register
// after reset a clearing pass zeroes rom and sram, 1536 rows (one row a cycle)
// a stalled output holds the item in the result step until the register frees
`include "physical_memory_region_decoder_assert.svh"

module physical_memory_region_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [31:0]                 i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // opcode, address, access_bytes, write_data, zero pad
    input  logic [pmrd_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // read_data, status, zero pad
    output logic [pmrd_pkg::OUT_W-1:0]  m_axis_tdata
);
    import pmrd_pkg::*;

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_ACCESS = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CLR_W-1:0] r_clr_cnt;
    logic [31:0]      r_main_base;
    logic             r_dev_en;
    logic             r_out_valid;
    logic [63:0]      r_out_rdata;
    logic [1:0]       r_out_status;
    logic             accept;
    logic             out_free;
    logic             load_out;
    logic             clr_last;
    t_req             req;
    logic [63:0]      bank_rdata;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign load_out = (r_state == S_RESULT) && out_free;
    assign clr_last = r_clr_cnt == CLR_W'(CLR_ROWS - 1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_base <= 32'h8000_0000;
            r_dev_en    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAIN_BASE: r_main_base <= i_cfg_wdata;
                CFG_DEV_EN:    r_dev_en    <= i_cfg_wdata[0];
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (clr_last) n_state = S_IDLE;
            S_IDLE:   if (accept) n_state = S_ACCESS;
            S_ACCESS: n_state = S_RESULT;
            S_RESULT: if (out_free) n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    assign s_axis_tready = r_state == S_IDLE;

    // decode on acceptance
    pmrd_decode u_decode (
        .i_clk           (i_clk),
        .i_load          (accept),
        .i_opcode        (s_axis_tdata[1:0]),
        .i_address       (s_axis_tdata[33:2]),
        .i_access_bytes  (s_axis_tdata[37:34]),
        .i_write_data    (s_axis_tdata[101:38]),
        .i_main_base     (r_main_base),
        .i_device_enable (r_dev_en),
        .o_req           (req)
    );

    // banked store
    pmrd_banks u_banks (
        .i_clk     (i_clk),
        .i_req     (req),
        .i_issue   (r_state == S_ACCESS),
        .i_clr_en  (r_state == S_CLEAR),
        .i_clr_row (ROW_W'(MAIN_ROWS) + ROW_W'(r_clr_cnt)),
        .o_rdata   (bank_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_rdata  <= (req.access && !req.write) ? bank_rdata : 64'h0;
            r_out_status <= req.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_status, r_out_rdata};

    `PMRD_ASSERT_NEXT(a_accept_to_access, accept, r_state == S_ACCESS, "accepted item did not reach access step")
    `PMRD_ASSERT_NEXT(a_stall_holds, (r_state == S_RESULT) && r_out_valid && !m_axis_tready, r_state == S_RESULT, "result step left while output full")
    `PMRD_ASSERT_NOW(a_status_code, r_out_valid, (r_out_status == ST_DONE) || (r_out_status == ST_DEVICE) || (r_out_status == ST_OOB), "unknown status code")
    `PMRD_ASSERT_NOW(a_fail_zero, r_out_valid && (r_out_status != ST_DONE), r_out_rdata == 64'h0, "failed item carries read data")

endmodule

/* design/pmrd_ram.sv */
module pmrd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

/* design/pmrd_decode.sv */
module pmrd_decode (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic [1:0]    i_opcode,
    input  logic [31:0]   i_address,
    input  logic [3:0]    i_access_bytes,
    input  logic [63:0]   i_write_data,
    input  logic [31:0]   i_main_base,
    input  logic          i_device_enable,
    output pmrd_pkg::t_req o_req
);
    import pmrd_pkg::*;

    logic [31:0]      off_main, off_rom, off_sram;
    logic             hit_main, hit_rom, hit_sram;
    logic             hit;
    logic [31:0]      sel_off;
    logic [32:0]      sel_size;
    logic [ROW_W-1:0] sel_row_base;
    logic [32:0]      end_sum;
    logic             len_ok;
    logic             op_ok;
    t_req             n_req;
    t_req             r_req;

    // region offsets and hits
    assign off_main = i_address - i_main_base;
    assign off_rom  = i_address - ROM_BASE;
    assign off_sram = i_address - SRAM_ORIGIN;
    assign hit_main = off_main < 32'(MAIN_BYTES);
    assign hit_rom  = (i_opcode != OP_WRITE) && (off_rom < 32'(ROM_BYTES));
    assign hit_sram = off_sram < 32'(SRAM_BYTES);
    assign hit      = hit_main || hit_rom || hit_sram;

    // region priority: main, rom, sram
    always_comb begin
        priority if (hit_main) begin
            sel_off      = off_main;
            sel_size     = 33'(MAIN_BYTES);
            sel_row_base = '0;
        end else if (hit_rom) begin
            sel_off      = off_rom;
            sel_size     = 33'(ROM_BYTES);
            sel_row_base = ROW_W'(MAIN_ROWS);
        end else begin
            sel_off      = off_sram;
            sel_size     = 33'(SRAM_BYTES);
            sel_row_base = ROW_W'(MAIN_ROWS + ROM_ROWS);
        end
    end

    assign end_sum = {1'b0, sel_off} + 33'(i_access_bytes);
    assign len_ok  = (i_access_bytes == 4'd1) || (i_access_bytes == 4'd2) ||
                     (i_access_bytes == 4'd4) || (i_access_bytes == 4'd8);
    assign op_ok   = i_opcode != OP_RSVD;

    // status and bank request
    always_comb begin
        n_req.write = i_opcode != OP_READ;
        n_req.row   = sel_row_base + ROW_W'(sel_off >> LANE_W);
        n_req.lane  = sel_off[LANE_W-1:0];
        n_req.len   = i_access_bytes;
        n_req.wdata = i_write_data;
        priority if (!op_ok || !len_ok) begin
            n_req.status = ST_OOB;
        end else if (!hit) begin
            n_req.status = i_device_enable ? ST_DEVICE : ST_OOB;
        end else if (end_sum > sel_size) begin
            n_req.status = ST_OOB;
        end else begin
            n_req.status = ST_DONE;
        end
        n_req.access = n_req.status == ST_DONE;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_req <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

/* design/pmrd_banks.sv */
module pmrd_banks (
    input  logic                   i_clk,
    input  pmrd_pkg::t_req         i_req,
    input  logic                   i_issue,
    input  logic                   i_clr_en,
    input  logic [pmrd_pkg::ROW_W-1:0] i_clr_row,
    output logic [63:0]            o_rdata
);
    import pmrd_pkg::*;

    logic [7:0] bank_q [LANES];

    // one byte bank per lane; an unaligned item wraps into the next row
    for (genvar b = 0; b < LANES; b++) begin : g_bank
        logic [LANE_W-1:0] idx;
        logic              active;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  addr;
        logic              we;
        logic              re;
        logic [7:0]        wdata;

        assign idx    = LANE_W'(b) - i_req.lane;
        assign active = {1'b0, idx} < i_req.len;
        assign row    = i_req.row + ROW_W'(LANE_W'(b) < i_req.lane);
        assign addr   = i_clr_en ? i_clr_row : row;
        assign we     = i_clr_en || (i_issue && i_req.access && i_req.write && active);
        assign re     = !i_clr_en && i_issue && i_req.access && !i_req.write && active;
        assign wdata  = i_clr_en ? 8'h00 : i_req.wdata[idx*8 +: 8];

        pmrd_ram #(
            .WIDTH (8),
            .DEPTH (TOTAL_ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_re    (re),
            .i_addr  (addr),
            .i_wdata (wdata),
            .o_rdata (bank_q[b])
        );
    end

    // rotate bank bytes back into item order, unused bytes zero
    always_comb begin
        logic [LANE_W-1:0] src;
        for (int i = 0; i < LANES; i++) begin
            src = i_req.lane + LANE_W'(i);
            o_rdata[i*8 +: 8] = (4'(i) < i_req.len) ? bank_q[src] : 8'h00;
        end
    end

endmodule

/* bench/physical_memory_region_decoder_test.sv */
module physical_memory_region_decoder_test;

    import pmrd_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PHASES       = 7;
    localparam int unsigned PHASE_ITEMS  = 290;
    localparam int unsigned SETTLE_TICKS = 4;

    // one bus access as packed on the input stream, opcode in the lowest bits
    typedef struct packed {
        logic [63:0] wdata;
        logic [3:0]  len;
        logic [31:0] addr;
        logic [1:0]  op;
    } t_bus_access;

    // one result as packed on the output stream, read data in the lowest bits
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] rdata;
    } t_bus_result;

    typedef enum {RGN_NONE, RGN_MAIN, RGN_ROM, RGN_SRAM} t_region;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_index = 1'b0;
    logic [31:0]         i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // opcode, address, access_bytes, write_data, zero pad
    logic [IN_W-1:0]     s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // read_data, status, zero pad
    logic [OUT_W-1:0]    m_axis_tdata;

    // register copies seen by both the stimulus and the prediction
    logic [31:0]         main_base_q = 32'h8000_0000;
    logic                dev_en_q = 1'b1;

    // predicted memory contents
    bit [7:0]            main_mem [MAIN_BYTES];
    bit [7:0]            rom_mem [ROM_BYTES];
    bit [7:0]            sram_mem [SRAM_BYTES];

    // main memory bytes already written by queued items
    bit                  main_written [MAIN_BYTES];

    t_bus_access         pending_accesses [$];
    t_bus_result         awaited_results [$];

    int                  mismatch_count = 0;
    int unsigned         hold_left = 0;
    logic                hold_req = 1'b0;

    physical_memory_region_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("physical_memory_region_decoder test failed");
        $finish;
    end

    // region selection and status for an access under the current registers
    function automatic logic [1:0] decode_status(input t_bus_access a, output t_region rgn,
                                                 output int unsigned off);
        logic [31:0] d_main;
        logic [31:0] d_rom;
        logic [31:0] d_sram;
        int unsigned size;
        d_main = a.addr - main_base_q;
        d_rom  = a.addr - ROM_BASE;
        d_sram = a.addr - SRAM_ORIGIN;
        rgn  = RGN_NONE;
        off  = 0;
        size = 0;
        if (a.op == OP_RSVD || !(a.len == 1 || a.len == 2 || a.len == 4 || a.len == 8))
            return ST_OOB;
        if (d_main < MAIN_BYTES) begin
            rgn = RGN_MAIN;
            off = d_main;
            size = MAIN_BYTES;
        end else if (a.op != OP_WRITE && d_rom < ROM_BYTES) begin
            rgn = RGN_ROM;
            off = d_rom;
            size = ROM_BYTES;
        end else if (d_sram < SRAM_BYTES) begin
            rgn = RGN_SRAM;
            off = d_sram;
            size = SRAM_BYTES;
        end
        if (rgn == RGN_NONE)
            return dev_en_q ? ST_DEVICE : ST_OOB;
        // last byte beyond the region of the first byte
        if (off + a.len > size) begin
            rgn = RGN_NONE;
            return ST_OOB;
        end
        return ST_DONE;
    endfunction

    // work out the result of an accepted item and update the predicted stores
    task automatic apply_access(input t_bus_access a);
        t_region     rgn;
        int unsigned off;
        t_bus_result res;
        logic        rd;
        res.rdata  = '0;
        res.status = decode_status(a, rgn, off);
        rd = (a.op == OP_READ);
        if (res.status == ST_DONE) begin
            for (int i = 0; i < a.len; i++) begin
                case (rgn)
                    RGN_MAIN: begin
                        if (rd) res.rdata[8*i +: 8] = main_mem[off+i];
                        else main_mem[off+i] = a.wdata[8*i +: 8];
                    end
                    RGN_ROM: begin
                        if (rd) res.rdata[8*i +: 8] = rom_mem[off+i];
                        else rom_mem[off+i] = a.wdata[8*i +: 8];
                    end
                    RGN_SRAM: begin
                        if (rd) res.rdata[8*i +: 8] = sram_mem[off+i];
                        else sram_mem[off+i] = a.wdata[8*i +: 8];
                    end
                    default: ;
                endcase
            end
        end
        awaited_results.push_back(res);
    endtask

    // queue an item, never reading main memory bytes that were not written yet
    task automatic queue_access(input logic [1:0] op, input logic [31:0] addr,
                                input logic [3:0] len, input logic [63:0] data);
        t_bus_access a;
        t_region     rgn;
        int unsigned off;
        logic [1:0]  st;
        a.op = op;
        a.addr = addr;
        a.len = len;
        a.wdata = data;
        st = decode_status(a, rgn, off);
        if (st == ST_DONE && rgn == RGN_MAIN) begin
            if (a.op == OP_READ)
                for (int i = 0; i < a.len; i++)
                    if (!main_written[off+i]) a.op = OP_WRITE;
            if (a.op != OP_READ)
                for (int i = 0; i < a.len; i++)
                    main_written[off+i] = 1'b1;
        end
        pending_accesses.push_back(a);
    endtask

    // offset into a region, mostly near the start, sometimes anywhere or at the end
    function automatic int unsigned region_offset(input int unsigned size);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12) return $urandom_range(0, 255);
        if (r < 17) return $urandom_range(0, size - 1);
        return size - $urandom_range(1, 12);
    endfunction

    task automatic queue_random_access();
        int unsigned r;
        logic [1:0]  op;
        logic [3:0]  len;
        logic [31:0] addr;
        logic [31:0] base;
        r = $urandom_range(0, 99);
        op = (r < 40) ? OP_READ : (r < 68) ? OP_WRITE : (r < 95) ? OP_LOAD : OP_RSVD;
        if ($urandom_range(0, 9) == 0) len = 4'($urandom_range(0, 15));
        else len = 4'(1 << $urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0, 1, 2: addr = main_base_q + region_offset(MAIN_BYTES);
            3, 4: addr = ROM_BASE + region_offset(ROM_BYTES);
            5, 6: addr = SRAM_ORIGIN + region_offset(SRAM_BYTES);
            7: begin
                // just below one of the region bases
                r = $urandom_range(0, 2);
                base = (r == 0) ? main_base_q : (r == 1) ? ROM_BASE : SRAM_ORIGIN;
                addr = base - $urandom_range(1, 8);
            end
            default: addr = $urandom;
        endcase
        queue_access(op, addr, len, {$urandom, $urandom});
    endtask

    // idle cycles before an item or a result, with runs of back-to-back items
    function automatic int unsigned draw_gap(inout int unsigned run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_accesses.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAIN_BASE) main_base_q = val;
        else dev_en_q = val[0];
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // sender: offers queued items, predicts each one on acceptance
    t_bus_access offered;
    int unsigned send_gap = 0;
    int unsigned send_run = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                apply_access(offered);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_accesses.size() != 0) begin
                    offered = pending_accesses.pop_front();
                    s_axis_tdata <= {{(IN_W - $bits(t_bus_access)){1'b0}}, offered};
                    s_axis_tvalid <= 1'b1;
                    send_gap = draw_gap(send_run);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
            hold_req <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: checks every accepted result against the oldest prediction
    t_bus_result got;
    t_bus_result want;
    logic        ready_next;
    int unsigned recv_stall = 0;
    int unsigned recv_run = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(t_bus_result)-1:0];
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: data %h status %0d",
                                              got.rdata, got.status));
                end else begin
                    want = awaited_results.pop_front();
                    if (got.rdata !== want.rdata || got.status !== want.status)
                        report_mismatch($sformatf(
                            "result mismatch: expected data %h status %0d, got data %h status %0d",
                            want.rdata, want.status, got.rdata, got.status));
                end
                recv_stall = draw_gap(recv_run);
            end
            if (hold_left != 0) begin
                ready_next = 1'b0;
            end else if (recv_stall != 0) begin
                recv_stall--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_axis_tready <= ready_next;
        end
    end

    // stimulus
    logic [31:0] phase_base [PHASES] = '{32'h8000_0000, 32'h0000_0000, 32'h2000_0800,
                                         32'h0f00_1000, 32'hffff_ffff, 32'h0,
                                         32'h8000_0000};
    bit          phase_dev [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items under reset register values
        queue_access(OP_READ, ROM_BASE, 8, '0);
        queue_access(OP_READ, SRAM_ORIGIN, 8, '0);
        queue_access(OP_LOAD, ROM_BASE, 8, 64'h0123_4567_89ab_cdef);
        queue_access(OP_READ, ROM_BASE + 3, 4, '0);
        // plain write to rom goes to the device port and leaves the rom alone
        queue_access(OP_WRITE, ROM_BASE, 8, '1);
        queue_access(OP_READ, ROM_BASE, 8, '0);
        queue_access(OP_LOAD, ROM_BASE + ROM_BYTES - 8, 8, 64'hfedc_ba98_7654_3210);
        queue_access(OP_LOAD, ROM_BASE + ROM_BYTES - 4, 8, '1);
        queue_access(OP_READ, ROM_BASE + ROM_BYTES - 1, 1, '0);
        queue_access(OP_WRITE, SRAM_ORIGIN + SRAM_BYTES - 2, 2, 64'hffff);
        queue_access(OP_LOAD, SRAM_ORIGIN + 5, 8, 64'h5a5a_a5a5_0f0f_f0f0);
        queue_access(OP_READ, SRAM_ORIGIN + SRAM_BYTES - 8, 8, '0);
        queue_access(OP_READ, SRAM_ORIGIN + SRAM_BYTES - 7, 8, '0);
        queue_access(OP_WRITE, main_base_q, 8, '1);
        queue_access(OP_READ, main_base_q + 1, 4, '0);
        queue_access(OP_LOAD, main_base_q + MAIN_BYTES - 8, 8, 64'h8000_0000_0000_0001);
        queue_access(OP_READ, main_base_q + MAIN_BYTES - 1, 1, '0);
        queue_access(OP_WRITE, main_base_q + MAIN_BYTES - 2, 4, '1);
        // lengths other than 1, 2, 4 and 8
        queue_access(OP_READ, main_base_q, 3, '0);
        queue_access(OP_WRITE, main_base_q, 0, '1);
        queue_access(OP_LOAD, SRAM_ORIGIN, 15, '1);
        // unused opcode
        queue_access(OP_RSVD, SRAM_ORIGIN, 1, '1);
        // unmapped accesses
        queue_access(OP_READ, 32'h0000_0000, 8, '0);
        queue_access(OP_WRITE, 32'hffff_ffff, 8, '1);
        wait_idle();

        // random phases over several register settings
        phase_base[5] = $urandom;
        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_MAIN_BASE, phase_base[p]);
            write_reg(CFG_DEV_EN, {31'b0, phase_dev[p]});
            if (p == 3) begin
                // sender pauses halfway until the block has drained
                for (int n = 0; n < PHASE_ITEMS / 2; n++) queue_random_access();
                wait_idle();
                for (int n = PHASE_ITEMS / 2; n < PHASE_ITEMS; n++) queue_random_access();
            end else begin
                for (int n = 0; n < PHASE_ITEMS; n++) queue_random_access();
            end
            if (p == 2) begin
                // receiver backs off while items keep coming
                @(negedge i_clk);
                hold_req = 1'b1;
            end
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("physical_memory_region_decoder test passed");
        else
            $display("physical_memory_region_decoder test failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/pmrd_pkg.sv
design/pmrd_ram.sv
design/pmrd_decode.sv
design/pmrd_banks.sv
design/physical_memory_region_decoder.sv
bench/physical_memory_region_decoder_test.sv
